FILE: rtl/hrmc_pkg.sv
// Package for the pressure relay menu controller: constants, state types, channel payloads.
// No dependencies.
`default_nettype none
package hrmc_pkg;
    localparam int WINDOW_DEF      = 50;
    localparam int SAMPLE_BITS_DEF = 10;
    localparam int UPPER_MAX_DEF   = 120;
    localparam int LOWER_MAX_DEF   = 118;
    localparam int SAMPLE_W        = SAMPLE_BITS_DEF;
    localparam int TICK_W          = 14;
    localparam int SP_W            = 7;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 14;

    localparam logic [2:0] CFG_HOLD   = 3'd0;
    localparam logic [2:0] CFG_REPEAT = 3'd1;
    localparam logic [2:0] CFG_BLINK  = 3'd2;
    localparam logic [2:0] CFG_CALIB  = 3'd3;
    localparam logic [2:0] CFG_SSHOW  = 3'd4;
    localparam logic [2:0] CFG_SDARK  = 3'd5;
    localparam logic [2:0] CFG_COARSE = 3'd6;
    localparam logic [2:0] CFG_GAP    = 3'd7;

    localparam logic [7:0] PAT_A = 8'b01010101;
    localparam logic [7:0] PAT_B = 8'b10101010;

    typedef enum logic [1:0] {LV_OFF = 2'd0, LV_ON = 2'd1, LV_ASLEEP = 2'd2} level_t;

    typedef enum logic [4:0] {
        M_PRESS = 5'd0, M_UP = 5'd1, M_UP_FINE = 5'd2, M_UP_COARSE = 5'd3,
        M_LO = 5'd4, M_LO_FINE = 5'd5, M_LO_COARSE = 5'd6, M_CAL = 5'd7,
        M_CAL_A = 5'd8, M_CAL_B = 5'd9, M_CAL_DONE = 5'd10, M_TEST_A = 5'd11,
        M_TEST_B = 5'd12, M_TEST_C = 5'd13, M_TEST_D = 5'd14, M_SHOW = 5'd15,
        M_SLEEP_LIT = 5'd16, M_SLEEP_DARK = 5'd17
    } menu_t;

    typedef enum logic [2:0] {
        SQ_IDLE, SQ_RING, SQ_AVG, SQ_MENU, SQ_DIV_PCT, SQ_OUT
    } seq_t;

    typedef struct packed {
        logic                sample_valid;
        logic [SAMPLE_W-1:0] sample;
        logic                select_pressed;
        logic                up_pressed;
        logic                down_pressed;
    } tick_t;

    typedef struct packed {
        logic [7:0] display_byte;
        logic [2:0] mode_leds;
        logic       relay_on;
    } show_t;

    typedef struct packed {
        logic        start;
        logic [23:0] dividend;
        logic [15:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [23:0] quotient;
    } div_rsp_t;
endpackage
`default_nettype wire

FILE: rtl/hrmc_if.sv
// Valid/ready channel interface carrying one payload struct.
// Depends on nothing; payload type given as parameter.
`default_nettype none
interface hrmc_if #(parameter type payload_t = logic) (input wire logic clk);
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/hysteresis_relay_menu_controller.sv
// Top level: tick sequencer, sample ring memory, relay and menu logic.
// Depends on hrmc_pkg, hrmc_if, hrmc_div.
//
// Each tick item passes through the sequencer states in order: SQ_RING updates the
// ring memory and window sum, SQ_AVG forms the window average by reciprocal
// multiply, SQ_MENU does the relay and menu update, loads the output register and
// starts the 24-step divider for the percent of full scale, SQ_DIV_PCT waits for
// the quotient, and SQ_OUT raises the result valid. With a zero full scale the
// divide is skipped. The input is not ready while an item is in progress or while
// a result waits. After reset a clearing pass writes every ring memory entry
// before the first item is taken; configuration writes are taken at any time.
`default_nettype none
module hysteresis_relay_menu_controller #(
    parameter int WINDOW      = hrmc_pkg::WINDOW_DEF,
    parameter int UPPER_MAX   = hrmc_pkg::UPPER_MAX_DEF,
    parameter int LOWER_MAX   = hrmc_pkg::LOWER_MAX_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    hrmc_if.sink      in_ch,
    hrmc_if.source    out_ch,
    input  wire logic                              cfg_we,
    input  wire logic [hrmc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [hrmc_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import hrmc_pkg::*;
    localparam int SAMPLE_BITS = SAMPLE_BITS_DEF;
    localparam int PW = $clog2(WINDOW);
    localparam logic [SAMPLE_W-1:0] SINIT = SAMPLE_W'(1 << (SAMPLE_BITS - 1));
    localparam logic [15:0] SUM_INIT = 16'(WINDOW * (1 << (SAMPLE_BITS - 1)));
    localparam logic [SAMPLE_W-1:0] SMASK = SAMPLE_W'((1 << SAMPLE_BITS) - 1);
    localparam logic [PW-1:0] LAST = PW'(WINDOW - 1);
    localparam logic [SP_W-1:0] UMAX = SP_W'(UPPER_MAX);
    localparam logic [SP_W-1:0] LMAX = SP_W'(LOWER_MAX);
    // floor(sum / WINDOW) as (sum * RECIP) >> RECIP_SH, exact for 16-bit sums
    localparam int RECIP_SH = 22;
    localparam logic [21:0] RECIP = 22'(((1 << RECIP_SH) + WINDOW - 1) / WINDOW);

    // config registers
    logic [TICK_W-1:0] hold_reg, rep_reg, blink_reg, calib_reg, sshow_reg, sdark_reg;
    logic [3:0] coarse_reg, gap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg   <= 14'd5000;
            rep_reg    <= 14'd1000;
            blink_reg  <= 14'd500;
            calib_reg  <= 14'd2500;
            sshow_reg  <= 14'd10000;
            sdark_reg  <= 14'd1000;
            coarse_reg <= 4'd5;
            gap_reg    <= 4'd2;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HOLD:   hold_reg   <= cfg_data;
                CFG_REPEAT: rep_reg    <= cfg_data;
                CFG_BLINK:  blink_reg  <= cfg_data;
                CFG_CALIB:  calib_reg  <= cfg_data;
                CFG_SSHOW:  sshow_reg  <= cfg_data;
                CFG_SDARK:  sdark_reg  <= cfg_data;
                CFG_COARSE: coarse_reg <= cfg_data[3:0];
                CFG_GAP:    gap_reg    <= cfg_data[3:0];
                default:    ;
            endcase
        end
    end

    // sample ring memory
    logic [SAMPLE_W-1:0] ring_mem [WINDOW];
    logic [SAMPLE_W-1:0] ring_rd;
    logic                ring_we;
    logic [PW-1:0]       ring_wa;
    logic [SAMPLE_W-1:0] ring_wd;
    logic [PW-1:0]       ptr_reg, ptr_next;

    always_ff @(posedge clk)
    begin
        if (ring_we)
            ring_mem[ring_wa] <= ring_wd;
        ring_rd <= ring_mem[ptr_reg];
    end

    // state
    seq_t   sq_reg, sq_next;
    level_t lv_reg, lv_next;
    menu_t  mn_reg, mn_next;
    logic [SP_W-1:0]     up_reg, up_next, lo_reg, lo_next;
    logic [SAMPLE_W-1:0] fs_reg, fs_next;
    logic [15:0]         sum_reg, sum_next;
    logic [7:0]          pct_reg, pct_next;
    logic                selp_reg, selp_next, sreq_reg, sreq_next;
    logic [TICK_W-1:0]   fast_reg, fast_next, slow_reg, slow_next;
    logic                clr_reg, clr_next;
    logic [PW-1:0]       clr_cnt_reg, clr_cnt_next;
    logic [SAMPLE_W-1:0] avg_reg, avg_next;
    logic [37:0]         avg_prod;
    logic [10:0]         ob_reg, ob_next;
    logic                ov_reg, ov_next;
    logic [SAMPLE_W-1:0] smp_reg, smp_next;
    logic                sv_reg, sv_next, sel_lv_reg, sel_lv_next;
    logic                bu_reg, bu_next, bd_reg, bd_next;

    div_req_t dreq;
    div_rsp_t drsp;
    hrmc_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    assign avg_prod = 38'(sum_reg) * 38'(RECIP);

    // setpoint step helpers (signed 9-bit math)
    logic signed [8:0] su_u, su_l, sl_l, sl_u;
    logic signed [8:0] dlt, g9;
    logic [7:0] disp;
    logic [2:0] leds;
    logic       relay, sel, held, coarse, isup;
    logic [TICK_W-1:0] fdec, sdec;

    always_comb
    begin
        g9   = $signed({5'd0, gap_reg});
        sq_next = sq_reg; lv_next = lv_reg; mn_next = mn_reg;
        up_next = up_reg; lo_next = lo_reg; fs_next = fs_reg;
        sum_next = sum_reg; pct_next = pct_reg; selp_next = selp_reg;
        sreq_next = sreq_reg; fast_next = fast_reg; slow_next = slow_reg;
        clr_next = clr_reg; clr_cnt_next = clr_cnt_reg; avg_next = avg_reg;
        ob_next = ob_reg; ov_next = ov_reg; ptr_next = ptr_reg;
        smp_next = smp_reg; sv_next = sv_reg; sel_lv_next = sel_lv_reg;
        bu_next = bu_reg; bd_next = bd_reg;
        ring_we = 1'b0; ring_wa = ptr_reg; ring_wd = smp_reg;
        dreq = '0;
        disp = '0; leds = '0; relay = 1'b0; sel = 1'b0; held = 1'b0;
        coarse = 1'b0; isup = 1'b0; dlt = '0;
        su_u = '0; su_l = '0; sl_l = '0; sl_u = '0;
        fdec = (fast_reg != '0) ? fast_reg - 14'd1 : '0;
        sdec = (slow_reg != '0) ? slow_reg - 14'd1 : '0;
        in_ch.ready = 1'b0;
        if (out_ch.ready)
            ov_next = 1'b0;

        if (clr_reg)
        begin
            ring_we = 1'b1;
            ring_wa = clr_cnt_reg;
            ring_wd = SINIT;
            clr_cnt_next = clr_cnt_reg + PW'(1);
            if (clr_cnt_reg == LAST)
                clr_next = 1'b0;
        end

        case (sq_reg)
            SQ_IDLE:
            begin
                in_ch.ready = !clr_reg && !ov_reg;
                if (in_ch.valid && !clr_reg && !ov_reg)
                begin
                    smp_next    = in_ch.data.sample & SMASK;
                    sv_next     = in_ch.data.sample_valid;
                    sel_lv_next = in_ch.data.select_pressed;
                    bu_next     = in_ch.data.up_pressed;
                    bd_next     = in_ch.data.down_pressed;
                    sq_next     = SQ_RING;
                end
            end
            SQ_RING:
            begin
                // ring_rd holds the oldest entry at ptr_reg
                if (sv_reg)
                begin
                    sum_next = sum_reg + 16'(smp_reg) - 16'(ring_rd);
                    ring_we  = 1'b1;
                    ring_wa  = ptr_reg;
                    ring_wd  = smp_reg;
                    ptr_next = (ptr_reg == LAST) ? '0 : ptr_reg + PW'(1);
                end
                sq_next = SQ_AVG;
            end
            SQ_AVG:
            begin
                avg_next = avg_prod[RECIP_SH +: SAMPLE_W];
                sq_next  = SQ_MENU;
            end
            SQ_MENU:
            begin
                fast_next = fdec;
                slow_next = sdec;
                sel  = sel_lv_reg && !selp_reg;
                selp_next = sel_lv_reg;
                held = bu_reg != bd_reg;

                case (lv_reg)
                    LV_OFF:
                        if ({1'b0, pct_reg} > {2'd0, up_reg}) lv_next = LV_ON;
                        else if (sreq_reg) lv_next = LV_ASLEEP;
                    LV_ON:
                    begin
                        relay = 1'b1;
                        if ({1'b0, pct_reg} < {2'd0, lo_reg}) lv_next = LV_OFF;
                        else if (sreq_reg) lv_next = LV_ASLEEP;
                    end
                    LV_ASLEEP:
                        if (!sreq_reg) lv_next = LV_OFF;
                    default: lv_next = LV_OFF;
                endcase

                case (mn_reg)
                    M_PRESS:
                    begin
                        disp = pct_reg; leds = 3'd1;
                        if (sel) mn_next = M_UP;
                    end
                    M_UP, M_LO:
                    begin
                        disp = {1'b0, (mn_reg == M_UP) ? up_reg : lo_reg};
                        leds = (mn_reg == M_UP) ? 3'd2 : 3'd3;
                        if (sel) mn_next = (mn_reg == M_UP) ? M_LO : M_CAL;
                        else if (held)
                        begin
                            slow_next = hold_reg;
                            fast_next = rep_reg;
                            mn_next = (mn_reg == M_UP) ? M_UP_FINE : M_LO_FINE;
                        end
                    end
                    M_UP_FINE, M_UP_COARSE, M_LO_FINE, M_LO_COARSE:
                    begin
                        isup   = (mn_reg == M_UP_FINE) || (mn_reg == M_UP_COARSE);
                        coarse = (mn_reg == M_UP_COARSE) || (mn_reg == M_LO_COARSE);
                        disp = {1'b0, isup ? up_reg : lo_reg};
                        leds = isup ? 3'd2 : 3'd3;
                        if (!held)
                        begin
                            if (isup)
                            begin
                                fast_next = '0;
                                slow_next = '0;
                            end
                            mn_next = isup ? M_UP : M_LO;
                        end
                        else if (fdec == '0)
                        begin
                            dlt = coarse ? $signed({5'd0, coarse_reg}) : 9'sd1;
                            if (!bu_reg) dlt = -dlt;
                            fast_next = rep_reg;
                            if (isup)
                            begin
                                su_u = $signed({2'd0, up_reg}) + dlt;
                                if (su_u < g9) su_u = g9;
                                if (su_u > $signed({2'd0, UMAX})) su_u = $signed({2'd0, UMAX});
                                su_l = $signed({2'd0, lo_reg});
                                if (su_l + g9 > su_u) su_l = (su_u >= g9) ? su_u - g9 : 9'sd0;
                                up_next = su_u[SP_W-1:0];
                                lo_next = su_l[SP_W-1:0];
                            end
                            else
                            begin
                                sl_l = $signed({2'd0, lo_reg}) + dlt;
                                if (sl_l > $signed({2'd0, LMAX})) sl_l = $signed({2'd0, LMAX});
                                if (sl_l < 9'sd0) sl_l = 9'sd0;
                                sl_u = $signed({2'd0, up_reg});
                                if (sl_l + g9 > sl_u)
                                begin
                                    sl_u = sl_l + g9;
                                    if (sl_u > $signed({2'd0, UMAX})) sl_u = $signed({2'd0, UMAX});
                                    if (sl_l + g9 > sl_u) sl_l = (sl_u >= g9) ? sl_u - g9 : 9'sd0;
                                end
                                up_next = sl_u[SP_W-1:0];
                                lo_next = sl_l[SP_W-1:0];
                            end
                        end
                        else if (!coarse && sdec == '0)
                        begin
                            slow_next = '0;
                            fast_next = rep_reg;
                            mn_next = isup ? M_UP_COARSE : M_LO_COARSE;
                        end
                    end
                    M_CAL, M_CAL_A, M_CAL_B:
                    begin
                        disp = (mn_reg == M_CAL) ? 8'd0 : ((mn_reg == M_CAL_A) ? 8'd1 : 8'd3);
                        leds = 3'd4;
                        if (sel)
                        begin
                            mn_next = M_TEST_A; slow_next = blink_reg;
                        end
                        else if (mn_reg == M_CAL)
                        begin
                            if (bu_reg)
                            begin
                                slow_next = calib_reg; mn_next = M_CAL_A;
                            end
                        end
                        else if (bu_reg && sdec == '0)
                        begin
                            if (mn_reg == M_CAL_A)
                            begin
                                slow_next = calib_reg; mn_next = M_CAL_B;
                            end
                            else
                            begin
                                slow_next = '0; mn_next = M_CAL_DONE;
                            end
                        end
                        else if (!bu_reg) mn_next = M_CAL;
                    end
                    M_CAL_DONE:
                    begin
                        leds = 3'd4;
                        fs_next = avg_reg & SMASK;
                        mn_next = M_PRESS;
                    end
                    M_TEST_A, M_TEST_B, M_TEST_C, M_TEST_D:
                    begin
                        disp = (mn_reg == M_TEST_A || mn_reg == M_TEST_D) ? PAT_A : PAT_B;
                        leds = (mn_reg == M_TEST_D) ? 3'd2 : 3'd5;
                        if (sel) mn_next = M_SHOW;
                        else if (sdec == '0)
                        begin
                            slow_next = blink_reg;
                            mn_next = (mn_reg == M_TEST_A) ? M_TEST_B :
                                      ((mn_reg == M_TEST_C) ? M_TEST_D : M_TEST_C);
                        end
                    end
                    M_SHOW:
                    begin
                        disp = pct_reg; leds = 3'd6;
                        if (bd_reg)
                        begin
                            mn_next = M_SLEEP_LIT; slow_next = sshow_reg;
                        end
                        else if (sel) mn_next = M_PRESS;
                    end
                    M_SLEEP_LIT, M_SLEEP_DARK:
                    begin
                        leds = (mn_reg == M_SLEEP_LIT) ? 3'd6 : 3'd0;
                        sreq_next = 1'b1;
                        if (sel)
                        begin
                            sreq_next = 1'b0; mn_next = M_PRESS;
                        end
                        if (sdec == '0)
                        begin
                            if (mn_reg == M_SLEEP_LIT)
                            begin
                                slow_next = sdark_reg; mn_next = M_SLEEP_DARK;
                            end
                            else
                            begin
                                slow_next = sshow_reg; mn_next = M_SLEEP_LIT;
                            end
                        end
                    end
                    default: mn_next = M_PRESS;
                endcase

                ob_next = {disp, leds};
                ov_next = 1'b0;
                if (fs_next == '0)
                begin
                    pct_next = 8'd255;
                    sq_next = SQ_OUT;
                end
                else
                begin
                    dreq.start    = 1'b1;
                    dreq.dividend = 24'(avg_reg) * 24'd100;
                    dreq.divisor  = 16'(fs_next);
                    sq_next = SQ_DIV_PCT;
                end
            end
            SQ_DIV_PCT:
            begin
                if (drsp.done)
                begin
                    pct_next = (drsp.quotient > 24'd255) ? 8'd255 : drsp.quotient[7:0];
                    sq_next = SQ_OUT;
                end
            end
            SQ_OUT:
            begin
                if (!ov_reg)
                begin
                    ov_next = 1'b1;
                    sq_next = SQ_IDLE;
                end
            end
            default: sq_next = SQ_IDLE;
        endcase
    end

    // relay bit is captured at menu time
    logic relay_reg, relay_next;
    assign relay_next = (sq_reg == SQ_MENU) ? relay : relay_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_reg <= SQ_IDLE; lv_reg <= LV_ASLEEP; mn_reg <= M_SLEEP_LIT;
            up_reg <= 7'd110; lo_reg <= 7'd108; fs_reg <= SINIT;
            sum_reg <= SUM_INIT; pct_reg <= 8'd100; selp_reg <= 1'b0;
            sreq_reg <= 1'b0; fast_reg <= '0; slow_reg <= '0;
            clr_reg <= 1'b1; clr_cnt_reg <= '0; ptr_reg <= '0; ov_reg <= 1'b0;
        end
        else
        begin
            sq_reg <= sq_next; lv_reg <= lv_next; mn_reg <= mn_next;
            up_reg <= up_next; lo_reg <= lo_next; fs_reg <= fs_next;
            sum_reg <= sum_next; pct_reg <= pct_next; selp_reg <= selp_next;
            sreq_reg <= sreq_next; fast_reg <= fast_next; slow_reg <= slow_next;
            clr_reg <= clr_next; clr_cnt_reg <= clr_cnt_next; ptr_reg <= ptr_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        avg_reg <= avg_next; ob_reg <= ob_next; smp_reg <= smp_next;
        sv_reg <= sv_next; sel_lv_reg <= sel_lv_next; bu_reg <= bu_next;
        bd_reg <= bd_next; relay_reg <= relay_next;
    end

    assign out_ch.valid             = ov_reg;
    assign out_ch.data.display_byte = ob_reg[10:3];
    assign out_ch.data.mode_leds    = ob_reg[2:0];
    assign out_ch.data.relay_on     = relay_reg;
endmodule
`default_nettype wire

FILE: rtl/hrmc_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on hrmc_pkg.
`default_nettype none
module hrmc_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire hrmc_pkg::div_req_t req,
    output hrmc_pkg::div_rsp_t     rsp
);
    import hrmc_pkg::*;
    logic [23:0] quo_reg, quo_next;
    logic [16:0] rem_reg, rem_next;
    logic [15:0] dvs_reg, dvs_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next, done_reg, done_next;
    logic [16:0] trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = '0;
        if (req.start)
        begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            cnt_next  = 5'd23;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            trial = {rem_reg[15:0], quo_reg[23]};
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = trial - {1'b0, dvs_reg};
                quo_next = {quo_reg[22:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[22:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;
endmodule
`default_nettype wire

FILE: rtl/hrmc_checker.sv
// Port-level checker for the controller, bound to the top level.
// Depends on hrmc_pkg (none directly) and the top-level ports.
`default_nettype none
module hrmc_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic [2:0] mode_leds,
    input wire logic [7:0] display_byte
);
    a_no_accept_after: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready) else $error("ready after transfer");
    a_no_out_with_in: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready) else $error("input taken while result waits");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable({display_byte, mode_leds}))
        else $error("result dropped");
    a_no_result_fast: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !out_valid) else $error("result too early");
endmodule

bind hysteresis_relay_menu_controller hrmc_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .mode_leds(out_ch.data.mode_leds), .display_byte(out_ch.data.display_byte)
);
`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for the pressure relay menu controller: drives millisecond
// ticks, predicts every result and compares field by field. Depends on hrmc_pkg, hrmc_if.
`default_nettype none
module tb_top;
    import hrmc_pkg::*;

    typedef struct packed {
        tick_t stim;
        logic  typed;
        show_t want;
    } row_t;

    localparam int WIN = WINDOW_DEF;
    localparam int IDLE_LIMIT = 5000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    hrmc_if #(.payload_t(tick_t)) in_ch (clk);
    hrmc_if #(.payload_t(show_t)) out_ch (clk);

    hysteresis_relay_menu_controller dut (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #2 clk = ~clk;

    // predictor state
    int hold_t, rep_t, blink_t, calib_t, sshow_t, sdark_t, coarse, gap;
    level_t lvl;
    menu_t menu;
    int up_sp, lo_sp, fs, ptr, wsum, pct, fast_cd, slow_cd;
    int ring [WIN];
    bit sel_prev, sleep_req;
    logic [17:0] menus_seen;

    show_t expected_q[$];
    logic typed_q[$];
    show_t typed_vals[$];
    int n_sent, n_results, n_relay, mismatches, idle_cycles;
    bit hold_done;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic void step_upper(int d);
        int u;
        u = up_sp + d;
        if (u < gap) u = gap;
        if (u > UPPER_MAX_DEF) u = UPPER_MAX_DEF;
        up_sp = u;
        if (lo_sp + gap > u) lo_sp = (u >= gap) ? u - gap : 0;
    endfunction

    function automatic void step_lower(int d);
        int l, u;
        l = lo_sp + d;
        if (l > LOWER_MAX_DEF) l = LOWER_MAX_DEF;
        if (l < 0) l = 0;
        lo_sp = l;
        if (l + gap > up_sp) begin
            u = l + gap;
            if (u > UPPER_MAX_DEF) u = UPPER_MAX_DEF;
            up_sp = u;
            if (l + gap > u) lo_sp = (u >= gap) ? u - gap : 0;
        end
    endfunction

    function automatic menu_t adjust(bit upper, bit crs, bit held, bit up, menu_t idle_m,
                                     menu_t self_m);
        int d;
        if (!held) begin
            if (upper) begin
                fast_cd = 0;
                slow_cd = 0;
            end
            return idle_m;
        end
        if (fast_cd == 0) begin
            d = crs ? coarse : 1;
            fast_cd = rep_t;
            if (!up) d = -d;
            if (upper) step_upper(d);
            else step_lower(d);
            return self_m;
        end
        if (!crs && slow_cd == 0) begin
            fast_cd = rep_t;
            return upper ? M_UP_COARSE : M_LO_COARSE;
        end
        return self_m;
    endfunction

    function automatic show_t predict_tick(tick_t t);
        show_t r;
        bit sel, held, up, dn;
        int disp, leds, avg, p;
        menu_t m, nx;
        disp = 0;
        leds = 0;
        r.relay_on = 1'b0;
        up = t.up_pressed;
        dn = t.down_pressed;
        if (fast_cd > 0) fast_cd--;
        if (slow_cd > 0) slow_cd--;
        if (t.sample_valid) begin
            wsum = wsum + int'(t.sample) - ring[ptr];
            ring[ptr] = int'(t.sample);
            ptr = (ptr + 1 >= WIN) ? 0 : ptr + 1;
        end
        sel = t.select_pressed && !sel_prev;
        sel_prev = t.select_pressed;
        held = up != dn;

        case (lvl)
            LV_OFF:
                if (pct > up_sp) lvl = LV_ON;
                else if (sleep_req) lvl = LV_ASLEEP;
            LV_ON:
            begin
                r.relay_on = 1'b1;
                if (pct < lo_sp) lvl = LV_OFF;
                else if (sleep_req) lvl = LV_ASLEEP;
            end
            LV_ASLEEP:
                if (!sleep_req) lvl = LV_OFF;
            default:
                lvl = LV_OFF;
        endcase

        m = menu;
        nx = m;
        menus_seen[m] = 1'b1;
        case (m)
            M_PRESS:
            begin
                disp = pct;
                leds = 1;
                if (sel) nx = M_UP;
            end
            M_UP, M_LO:
            begin
                disp = (m == M_UP) ? up_sp : lo_sp;
                leds = (m == M_UP) ? 2 : 3;
                if (sel) nx = (m == M_UP) ? M_LO : M_CAL;
                else if (held) begin
                    slow_cd = hold_t;
                    fast_cd = rep_t;
                    nx = (m == M_UP) ? M_UP_FINE : M_LO_FINE;
                end
            end
            M_UP_FINE, M_UP_COARSE:
            begin
                disp = up_sp;
                leds = 2;
                nx = adjust(1'b1, m == M_UP_COARSE, held, up, M_UP, m);
            end
            M_LO_FINE, M_LO_COARSE:
            begin
                disp = lo_sp;
                leds = 3;
                nx = adjust(1'b0, m == M_LO_COARSE, held, up, M_LO, m);
            end
            M_CAL, M_CAL_A, M_CAL_B:
            begin
                disp = (m == M_CAL) ? 0 : (m == M_CAL_A ? 1 : 3);
                leds = 4;
                if (sel) begin
                    nx = M_TEST_A;
                    slow_cd = blink_t;
                end else if (m == M_CAL) begin
                    if (up) begin
                        slow_cd = calib_t;
                        nx = M_CAL_A;
                    end
                end else if (up && slow_cd == 0) begin
                    if (m == M_CAL_A) begin
                        slow_cd = calib_t;
                        nx = M_CAL_B;
                    end else begin
                        slow_cd = 0;
                        nx = M_CAL_DONE;
                    end
                end else if (!up) nx = M_CAL;
            end
            M_CAL_DONE:
            begin
                leds = 4;
                fs = (wsum / WIN) & 10'h3FF;
                nx = M_PRESS;
            end
            M_TEST_A, M_TEST_B, M_TEST_C, M_TEST_D:
            begin
                disp = (m == M_TEST_A || m == M_TEST_D) ? PAT_A : PAT_B;
                leds = (m == M_TEST_D) ? 2 : 5;
                if (sel) nx = M_SHOW;
                else if (slow_cd == 0) begin
                    slow_cd = blink_t;
                    nx = (m == M_TEST_A) ? M_TEST_B : (m == M_TEST_C ? M_TEST_D : M_TEST_C);
                end
            end
            M_SHOW:
            begin
                disp = pct;
                leds = 6;
                if (dn) begin
                    nx = M_SLEEP_LIT;
                    slow_cd = sshow_t;
                end else if (sel) nx = M_PRESS;
            end
            M_SLEEP_LIT, M_SLEEP_DARK:
            begin
                leds = (m == M_SLEEP_LIT) ? 6 : 0;
                sleep_req = 1'b1;
                if (sel) begin
                    sleep_req = 1'b0;
                    nx = M_PRESS;
                end
                if (slow_cd == 0) begin
                    if (m == M_SLEEP_LIT) begin
                        slow_cd = sdark_t;
                        nx = M_SLEEP_DARK;
                    end else begin
                        slow_cd = sshow_t;
                        nx = M_SLEEP_LIT;
                    end
                end
            end
            default:
                nx = M_PRESS;
        endcase
        menu = nx;

        if (fs == 0) pct = 255;
        else begin
            avg = wsum / WIN;
            p = avg * 100 / fs;
            pct = (p > 255) ? 255 : p;
        end
        r.display_byte = disp[7:0];
        r.mode_leds = leds[2:0];
        return r;
    endfunction

    // input side: every transfer feeds the predictor
    always @(posedge clk) begin
        if (rst_n && in_ch.valid && in_ch.ready)
            expected_q.push_back(predict_tick(in_ch.data));
    end

    // output side: compare against the oldest expectation
    always @(posedge clk) begin
        show_t want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            n_results++;
            if (out_ch.data.relay_on) n_relay++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h at %0t", out_ch.data, $realtime);
            end else begin
                want = expected_q.pop_front();
                if (typed_q.size() > 0 && typed_q.pop_front()) want = typed_vals.pop_front();
                if (out_ch.data.display_byte !== want.display_byte ||
                    out_ch.data.mode_leds !== want.mode_leds ||
                    out_ch.data.relay_on !== want.relay_on) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: exp disp=%0d leds=%0d relay=%0d, got %0d %0d %0d",
                                 n_results, want.display_byte, want.mode_leds, want.relay_on,
                                 out_ch.data.display_byte, out_ch.data.mode_leds,
                                 out_ch.data.relay_on);
                end
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // receiver with random stalls and one long hold-off
    initial begin
        int g;
        out_ch.ready = 1'b0;
        wait (rst_n);
        forever begin
            if (!hold_done && n_results >= 600) begin
                hold_done = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (500) @(posedge clk);
            end
            g = gap_len();
            if (g > 0) begin
                out_ch.ready <= 1'b0;
                repeat (g) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!out_ch.valid) @(posedge clk);
        end
    end

    task automatic send_tick(tick_t t);
        int g;
        in_ch.valid <= 1'b1;
        in_ch.data <= t;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        n_sent++;
        g = gap_len();
        if (g > 0) begin
            in_ch.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_q.size() != 0) @(posedge clk);
        repeat (70) @(posedge clk);
    endtask

    task automatic write_regs(int v [8]);
        for (int i = 0; i < 8; i++) begin
            @(posedge clk);
            cfg_we <= 1'b1;
            cfg_index <= i[CFG_IDX_W-1:0];
            cfg_data <= v[i][CFG_DATA_W-1:0];
        end
        @(posedge clk);
        cfg_we <= 1'b0;
        hold_t = v[CFG_HOLD];
        rep_t = v[CFG_REPEAT];
        blink_t = v[CFG_BLINK];
        calib_t = v[CFG_CALIB];
        sshow_t = v[CFG_SSHOW];
        sdark_t = v[CFG_SDARK];
        coarse = v[CFG_COARSE];
        gap = v[CFG_GAP];
    endtask

    row_t dir_tab [21] = '{
        '{'{1'b0, 10'd0,    1'b0, 1'b0, 1'b0}, 1'b1, '{8'd0,   3'd6, 1'b0}},
        '{'{1'b0, 10'd0,    1'b1, 1'b0, 1'b0}, 1'b1, '{8'd0,   3'd0, 1'b0}},
        '{'{1'b1, 10'd1023, 1'b0, 1'b0, 1'b0}, 1'b1, '{8'd100, 3'd1, 1'b0}},
        '{'{1'b1, 10'd0,    1'b1, 1'b0, 1'b0}, 1'b0, '0},
        '{'{1'b0, 10'd0,    1'b0, 1'b1, 1'b0}, 1'b0, '0},
        '{'{1'b0, 10'd0,    1'b0, 1'b1, 1'b0}, 1'b0, '0},
        '{'{1'b0, 10'd0,    1'b0, 1'b1, 1'b1}, 1'b0, '0},
        '{'{1'b1, 10'd1023, 1'b0, 1'b0, 1'b1}, 1'b0, '0},
        '{'{1'b0, 10'd0,    1'b1, 1'b0, 1'b0}, 1'b0, '0},
        '{'{1'b1, 10'd512,  1'b0, 1'b0, 1'b1}, 1'b0, '0},
        '{'{1'b0, 10'd0,    1'b0, 1'b1, 1'b0}, 1'b0, '0},
        '{'{1'b0, 10'd0,    1'b1, 1'b0, 1'b0}, 1'b0, '0},
        '{'{1'b0, 10'd0,    1'b0, 1'b1, 1'b0}, 1'b0, '0},
        '{'{1'b0, 10'd0,    1'b0, 1'b0, 1'b0}, 1'b0, '0},
        '{'{1'b0, 10'd0,    1'b1, 1'b0, 1'b0}, 1'b0, '0},
        '{'{1'b1, 10'd1023, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
        '{'{1'b0, 10'd0,    1'b1, 1'b0, 1'b0}, 1'b0, '0},
        '{'{1'b0, 10'd0,    1'b0, 1'b0, 1'b0}, 1'b0, '0},
        '{'{1'b0, 10'd0,    1'b1, 1'b0, 1'b0}, 1'b0, '0},
        '{'{1'b1, 10'd0,    1'b1, 1'b1, 1'b1}, 1'b0, '0},
        '{'{1'b0, 10'd0,    1'b0, 1'b0, 1'b0}, 1'b0, '0}
    };

    initial begin
        int regs [8];
        int target, btn, n_items, s;
        tick_t t;
        bit sel_lvl;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        hold_t = 5000; rep_t = 1000; blink_t = 500; calib_t = 2500;
        sshow_t = 10000; sdark_t = 1000; coarse = 5; gap = 2;
        lvl = LV_ASLEEP;
        menu = M_SLEEP_LIT;
        up_sp = 110; lo_sp = 108; fs = 512;
        foreach (ring[k]) ring[k] = 512;
        ptr = 0; wsum = WIN * 512; pct = 100;
        sel_prev = 0; sleep_req = 0; fast_cd = 0; slow_cd = 0;
        menus_seen = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_tab[i]) begin
            typed_q.push_back(dir_tab[i].typed);
            if (dir_tab[i].typed) typed_vals.push_back(dir_tab[i].want);
            send_tick(dir_tab[i].stim);
        end

        for (int ph = 0; ph < 6; ph++) begin
            drain();
            case (ph)
                0: regs = '{3, 2, 2, 2, 4, 3, 5, 2};
                1: regs = '{1, 1, 1, 1, 1, 1, 15, 15};
                2: regs = '{16383, 16383, 16383, 16383, 16383, 16383, 1, 0};
                default:
                    for (int i = 0; i < 8; i++)
                        regs[i] = (i >= CFG_COARSE) ? $urandom_range(i == CFG_GAP ? 0 : 1, 15)
                                                   : $urandom_range(1, 12);
            endcase
            write_regs(regs);
            n_items = (ph == 2) ? 100 : 300;
            target = $urandom_range(0, 1023);
            btn = 0;
            sel_lvl = 0;
            for (int n = 0; n < n_items; n++) begin
                if ($urandom_range(0, 60) == 0) target = $urandom_range(0, 1023);
                if ($urandom_range(0, 7) == 0) btn = $urandom_range(0, 3);
                if ($urandom_range(0, 5) == 0) sel_lvl = ~sel_lvl;
                case ($urandom_range(0, 9))
                    0: s = 0;
                    1: s = 1023;
                    2: s = $urandom_range(0, 1023);
                    default: s = target + $urandom_range(0, 80) - 40;
                endcase
                if (s < 0) s = 0;
                if (s > 1023) s = 1023;
                t.sample_valid = ($urandom_range(0, 3) != 0);
                t.sample = s[SAMPLE_W-1:0];
                t.select_pressed = sel_lvl;
                t.up_pressed = btn[0];
                t.down_pressed = btn[1];
                send_tick(t);
            end
        end

        drain();
        $display("%0d ticks sent, %0d results checked, %0d with relay on",
                 n_sent, n_results, n_relay);
        $display("%0d of 18 menu states visited, %0d mismatches",
                 $countones(menus_seen), mismatches);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
`default_nettype wire
